@@ design/pfd_pkg.sv @@
// Shared types and constants for the packet FIFO with duplicate filter.
`timescale 1ns / 1ps
`default_nettype none
package pfd_pkg;

  localparam int unsigned DefDepth    = 1024;
  localparam int unsigned DefIdBits   = 16;
  localparam int unsigned DefTimeBits = 32;

  localparam int unsigned LimitW     = 11;
  localparam int unsigned CountW     = 11;
  localparam int unsigned LimitReset = 1024;

  localparam int unsigned ApbDataW    = 32;
  localparam int unsigned PaddrW      = 3;
  localparam int unsigned RegIdxW     = 1;
  localparam int unsigned RegMemLimit = 0;

  typedef enum logic [1:0] {
    OpAdd     = 2'd0,
    OpForward = 2'd1,
    OpCount   = 2'd2,
    OpNop     = 2'd3
  } pfd_op_e;

endpackage
`default_nettype wire

@@ design/pfd_chan_if.sv @@
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface pfd_in_if
  import pfd_pkg::*;
#(
  parameter int unsigned ID_BITS   = DefIdBits,
  parameter int unsigned TIME_BITS = DefTimeBits
);
  logic                 valid;
  logic                 ready;
  pfd_op_e              opcode;
  logic [ID_BITS-1:0]   source;
  logic [ID_BITS-1:0]   destination;
  logic [TIME_BITS-1:0] timestamp;
  logic [TIME_BITS-1:0] start_time;
  logic [TIME_BITS-1:0] end_time;

  modport source_mp (output valid, opcode, source, destination, timestamp, start_time,
                     end_time, input ready);
  modport sink_mp (input valid, opcode, source, destination, timestamp, start_time,
                   end_time, output ready);
endinterface

interface pfd_out_if
  import pfd_pkg::*;
#(
  parameter int unsigned ID_BITS   = DefIdBits,
  parameter int unsigned TIME_BITS = DefTimeBits
);
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [ID_BITS-1:0]   out_source;
  logic [ID_BITS-1:0]   out_destination;
  logic [TIME_BITS-1:0] out_timestamp;
  logic [CountW-1:0]    match_count;

  modport source_mp (output valid, ok, out_source, out_destination, out_timestamp,
                     match_count, input ready);
  modport sink_mp (input valid, ok, out_source, out_destination, out_timestamp,
                   match_count, output ready);
endinterface
`default_nettype wire

@@ design/pfd_store.sv @@
// Packet entry memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module pfd_store #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WORD_W = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WORD_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WORD_W-1:0]        rdata_o
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ design/packet_fifo_dedup_window_count.sv @@
// Top level: packet FIFO with duplicate filter and windowed destination count.
`timescale 1ns / 1ps
`default_nettype none
// Bounded FIFO of (source, destination, timestamp) packets held in one single-port-read
// RAM. An add or a count query walks the resident entries through the RAM read port, one
// entry per cycle; a forward reads only the head entry, and an empty-window count or
// opcode 3 reads none.
// One request is in flight at a time; the result sits in an output register so the next
// request is taken while it waits. memory_limit sits at APB address 0; write it only
// while the block is idle.
module packet_fifo_dedup_window_count
  import pfd_pkg::*;
#(
  parameter int unsigned DEPTH     = DefDepth,
  parameter int unsigned ID_BITS   = DefIdBits,
  parameter int unsigned TIME_BITS = DefTimeBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  pfd_in_if.sink_mp                in_if,
  pfd_out_if.source_mp             out_if,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PaddrW-1:0]   paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready
);

  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned OccW   = $clog2(DEPTH + 1);
  localparam int unsigned SumW   = OccW + 1;
  localparam int unsigned WordW  = 2 * ID_BITS + TIME_BITS;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFin
  } state_e;

  state_e               state_q;
  pfd_op_e              op_q;
  logic [ID_BITS-1:0]   src_q, dst_q;
  logic [TIME_BITS-1:0] ts_q, lo_q, hi_q;
  logic [AW-1:0]        head_q, rptr_q;
  logic [OccW-1:0]      occ_q, scan_n_q, k_q;
  logic                 pend_q, dup_q;
  logic [CountW-1:0]    cnt_q;
  logic [WordW-1:0]     fwd_q;
  logic [LimitW-1:0]    limit_q;

  logic                 out_valid_q, ok_q;
  logic [ID_BITS-1:0]   out_src_q, out_dst_q;
  logic [TIME_BITS-1:0] out_ts_q;
  logic [CountW-1:0]    out_cnt_q;

  logic                 ok_d;
  logic [ID_BITS-1:0]   out_src_d, out_dst_d;
  logic [TIME_BITS-1:0] out_ts_d;
  logic [CountW-1:0]    out_cnt_d;

  logic                 accept, out_free, issue, full, we;
  logic [WordW-1:0]     rdata, wdata;
  logic [ID_BITS-1:0]   rd_src, rd_dst;
  logic [TIME_BITS-1:0] rd_ts;
  logic                 rd_dup, rd_hit;
  logic [31:0]          eff_limit;
  logic [SumW-1:0]      tail_sum;
  logic [AW-1:0]        tail;
  logic                 cfg_wr;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign accept       = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_q == StIdle);
  assign out_free     = !out_valid_q || out_if.ready;
  assign issue        = (state_q == StScan) && (k_q != scan_n_q);

  assign {rd_src, rd_dst, rd_ts} = rdata;
  assign rd_dup = (rd_src == src_q) && (rd_dst == dst_q) && (rd_ts == ts_q);
  assign rd_hit = (rd_dst == dst_q) && (rd_ts >= lo_q) && (rd_ts <= hi_q);

  always_comb begin
    if (limit_q == '0) begin
      eff_limit = 32'd1;
    end else if (32'(limit_q) > 32'(DEPTH)) begin
      eff_limit = 32'(DEPTH);
    end else begin
      eff_limit = 32'(limit_q);
    end
  end

  always_comb begin
    ok_d      = 1'b0;
    out_src_d = '0;
    out_dst_d = '0;
    out_ts_d  = '0;
    out_cnt_d = '0;
    case (op_q)
      OpAdd:     ok_d = !dup_q;
      OpForward: begin
        if (occ_q != '0) begin
          ok_d                              = 1'b1;
          {out_src_d, out_dst_d, out_ts_d} = fwd_q;
        end
      end
      OpCount:   out_cnt_d = cnt_q;
      default:   ok_d      = 1'b0;
    endcase
  end

  assign full     = (32'(occ_q) >= eff_limit) && (occ_q != '0);
  assign tail_sum = SumW'(head_q) + SumW'(occ_q);
  assign tail     = (tail_sum >= SumW'(DEPTH)) ? AW'(tail_sum - SumW'(DEPTH)) : AW'(tail_sum);
  assign we       = (state_q == StFin) && out_free && (op_q == OpAdd) && !dup_q;
  assign wdata    = {src_q, dst_q, ts_q};

  pfd_store #(
    .DEPTH  (DEPTH),
    .WORD_W (WordW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (rptr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpNop;
      src_q       <= '0;
      dst_q       <= '0;
      ts_q        <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      head_q      <= '0;
      rptr_q      <= '0;
      occ_q       <= '0;
      scan_n_q    <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      dup_q       <= 1'b0;
      cnt_q       <= '0;
      fwd_q       <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      out_src_q   <= '0;
      out_dst_q   <= '0;
      out_ts_q    <= '0;
      out_cnt_q   <= '0;
    end else begin
      if ((state_q != StFin) && out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            op_q   <= in_if.opcode;
            src_q  <= in_if.source;
            dst_q  <= in_if.destination;
            ts_q   <= in_if.timestamp;
            lo_q   <= in_if.start_time;
            hi_q   <= in_if.end_time;
            rptr_q <= head_q;
            k_q    <= '0;
            pend_q <= 1'b0;
            dup_q  <= 1'b0;
            cnt_q  <= '0;
            case (in_if.opcode)
              OpAdd:     scan_n_q <= occ_q;
              OpForward: scan_n_q <= (occ_q != '0) ? OccW'(1) : '0;
              OpCount: begin
                scan_n_q <= (in_if.start_time <= in_if.end_time) ? occ_q : '0;
              end
              default:   scan_n_q <= '0;
            endcase
            state_q <= StScan;
          end
        end
        StScan: begin
          pend_q <= issue;
          if (issue) begin
            k_q    <= k_q + OccW'(1);
            rptr_q <= ptr_inc(rptr_q);
          end
          if (pend_q) begin
            dup_q <= dup_q | rd_dup;
            cnt_q <= cnt_q + CountW'(rd_hit);
            fwd_q <= rdata;
          end
          if (!issue) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            ok_q        <= ok_d;
            out_src_q   <= out_src_d;
            out_dst_q   <= out_dst_d;
            out_ts_q    <= out_ts_d;
            out_cnt_q   <= out_cnt_d;
            case (op_q)
              OpAdd: begin
                if (!dup_q) begin
                  if (full) begin
                    head_q <= ptr_inc(head_q);
                  end else begin
                    occ_q <= occ_q + OccW'(1);
                  end
                end
              end
              OpForward: begin
                if (occ_q != '0) begin
                  head_q <= ptr_inc(head_q);
                  occ_q  <= occ_q - OccW'(1);
                end
              end
              default: begin
              end
            endcase
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.ok              = ok_q;
  assign out_if.out_source      = out_src_q;
  assign out_if.out_destination = out_dst_q;
  assign out_if.out_timestamp   = out_ts_q;
  assign out_if.match_count     = out_cnt_q;

  // APB register file: memory_limit only
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[PaddrW-1:2] == RegIdxW'(RegMemLimit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitW'(LimitReset);
    end else if (cfg_wr) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  assign prdata = (paddr[PaddrW-1:2] == RegIdxW'(RegMemLimit)) ? ApbDataW'(limit_q) : '0;

endmodule
`default_nettype wire

@@ design/pfd_checker.sv @@
// Port-level checks for the packet FIFO, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pfd_checker
  import pfd_pkg::*;
#(
  parameter int unsigned ID_BITS   = DefIdBits,
  parameter int unsigned TIME_BITS = DefTimeBits
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic                 ok_i,
  input wire logic [ID_BITS-1:0]   out_source_i,
  input wire logic [ID_BITS-1:0]   out_destination_i,
  input wire logic [TIME_BITS-1:0] out_timestamp_i,
  input wire logic [CountW-1:0]    match_count_i,
  input wire logic                 pready_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(ok_i) && $stable(out_source_i) &&
      $stable(out_destination_i) && $stable(out_timestamp_i) && $stable(match_count_i))
    else $error("response transaction changed while stalled");

  a_ok_excl_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ok_i |-> match_count_i == '0)
    else $error("ok and nonzero match_count together");

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ok_i |-> out_source_i == '0 && out_destination_i == '0 &&
      out_timestamp_i == '0)
    else $error("packet fields nonzero without ok");

  a_count_no_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && match_count_i != '0 |-> out_source_i == '0 && out_timestamp_i == '0)
    else $error("count response carries packet data");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready low");

endmodule

bind packet_fifo_dedup_window_count pfd_checker #(
  .ID_BITS   (ID_BITS),
  .TIME_BITS (TIME_BITS)
) u_pfd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .ok_i              (out_if.ok),
  .out_source_i      (out_if.out_source),
  .out_destination_i (out_if.out_destination),
  .out_timestamp_i   (out_if.out_timestamp),
  .match_count_i     (out_if.match_count),
  .pready_i          (pready)
);
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the packet FIFO with duplicate filter and windowed count.
`timescale 1ns / 1ps
module tb;
  import pfd_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned MaxShown      = 40;

  typedef struct packed {
    logic [DefIdBits-1:0]   src;
    logic [DefIdBits-1:0]   dst;
    logic [DefTimeBits-1:0] ts;
  } pkt_t;

  typedef struct packed {
    pfd_op_e                op;
    pkt_t                   pkt;
    logic [DefTimeBits-1:0] lo;
    logic [DefTimeBits-1:0] hi;
  } req_t;

  typedef struct packed {
    logic              ok;
    pkt_t              pkt;
    logic [CountW-1:0] count;
  } reply_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PaddrW-1:0]   paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  wire  [ApbDataW-1:0] prdata;
  wire                 pready;

  logic drv_valid = 1'b0;
  req_t drv_req   = '0;
  logic rx_ready  = 1'b0;

  pfd_in_if  in_ch ();
  pfd_out_if out_ch ();

  assign in_ch.valid       = drv_valid;
  assign in_ch.opcode      = drv_req.op;
  assign in_ch.source      = drv_req.pkt.src;
  assign in_ch.destination = drv_req.pkt.dst;
  assign in_ch.timestamp   = drv_req.pkt.ts;
  assign in_ch.start_time  = drv_req.lo;
  assign in_ch.end_time    = drv_req.hi;
  assign out_ch.ready      = rx_ready;

  packet_fifo_dedup_window_count u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // shadow copy of the packet store
  logic [DefIdBits-1:0]   mirror_src [DefDepth];
  logic [DefIdBits-1:0]   mirror_dst [DefDepth];
  logic [DefTimeBits-1:0] mirror_ts  [DefDepth];
  int unsigned            mirror_head = 0;
  int unsigned            mirror_occ  = 0;
  logic [LimitW-1:0]      limit_reg   = LimitW'(LimitReset);

  req_t   pending_reqs [$];
  reply_t replies_due  [$];
  pkt_t   recent_pkts  [$];
  logic [DefTimeBits-1:0] ts_cursor = 32'h0000_1000;

  int unsigned n_errors    = 0;
  int unsigned n_checked   = 0;
  int unsigned n_added     = 0;
  int unsigned n_dups      = 0;
  int unsigned n_evicted   = 0;
  int unsigned n_forwarded = 0;
  int unsigned n_fwd_empty = 0;
  int unsigned n_counts    = 0;
  int unsigned n_hits      = 0;
  int unsigned peak_occ    = 0;
  int unsigned n_limits    = 0;

  int unsigned n_in_accepted = 0;
  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;
  int unsigned hold_left     = 0;
  logic        hold_armed    = 1'b1;
  logic [1:0]  rx_mode       = 2'd0;
  int unsigned rx_tick       = 0;
  logic        rx_next       = 1'b0;
  int unsigned idle_cycles   = 0;
  req_t        held_req      = '0;
  reply_t      seen          = '0;
  reply_t      want          = '0;

  task automatic flag_error(input string msg);
    if (n_errors < MaxShown) $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic reply_t serve_request(input req_t r);
    reply_t      rep;
    int unsigned lim;
    int unsigned k;
    int unsigned s;
    int unsigned cnt;
    logic        dup;
    rep = '0;
    dup = 1'b0;
    cnt = 0;
    case (r.op)
      OpAdd: begin
        for (k = 0; k < mirror_occ && !dup; k++) begin
          s = (mirror_head + k) % DefDepth;
          if (mirror_src[s] == r.pkt.src && mirror_dst[s] == r.pkt.dst &&
              mirror_ts[s] == r.pkt.ts) dup = 1'b1;
        end
        if (dup) begin
          n_dups++;
        end else begin
          lim = (limit_reg == 0) ? 1 : ((limit_reg > DefDepth) ? DefDepth : limit_reg);
          if (mirror_occ >= lim && mirror_occ > 0) begin
            mirror_head = (mirror_head + 1) % DefDepth;
            mirror_occ--;
            n_evicted++;
          end
          s = (mirror_head + mirror_occ) % DefDepth;
          mirror_src[s] = r.pkt.src;
          mirror_dst[s] = r.pkt.dst;
          mirror_ts[s]  = r.pkt.ts;
          mirror_occ++;
          if (mirror_occ > peak_occ) peak_occ = mirror_occ;
          rep.ok = 1'b1;
          n_added++;
        end
      end
      OpForward: begin
        if (mirror_occ > 0) begin
          rep.ok      = 1'b1;
          rep.pkt.src = mirror_src[mirror_head];
          rep.pkt.dst = mirror_dst[mirror_head];
          rep.pkt.ts  = mirror_ts[mirror_head];
          mirror_head = (mirror_head + 1) % DefDepth;
          mirror_occ--;
          n_forwarded++;
        end else begin
          n_fwd_empty++;
        end
      end
      OpCount: begin
        if (r.lo <= r.hi) begin
          for (k = 0; k < mirror_occ; k++) begin
            s = (mirror_head + k) % DefDepth;
            if (mirror_dst[s] == r.pkt.dst && mirror_ts[s] >= r.lo && mirror_ts[s] <= r.hi)
              cnt++;
          end
        end
        rep.count = CountW'(cnt);
        n_counts++;
        if (cnt != 0) n_hits++;
      end
      default: begin
      end
    endcase
    return rep;
  endfunction

  function automatic logic [DefIdBits-1:0] common_id(input int unsigned i);
    case (i)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      3: return 16'h0002;
      4: return 16'h8000;
      5: return 16'h7FFF;
      6: return 16'h00A5;
      default: return 16'h5A00;
    endcase
  endfunction

  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    int unsigned back;
    int unsigned ahead;
    pick      = $urandom_range(0, 99);
    r.op      = OpAdd;
    r.pkt.src = 16'($urandom);
    r.pkt.dst = 16'($urandom);
    r.pkt.ts  = $urandom;
    r.lo      = $urandom;
    r.hi      = $urandom;
    if (pick < 45) begin
      if ($urandom_range(0, 9) < 7) r.pkt.src = common_id($urandom_range(0, 7));
      if ($urandom_range(0, 9) < 7) r.pkt.dst = common_id($urandom_range(0, 7));
      if ($urandom_range(0, 9) != 0) begin
        ts_cursor = ts_cursor + $urandom_range(0, 3);
        r.pkt.ts  = ts_cursor;
      end
      recent_pkts.insert(recent_pkts.size(), r.pkt);
      if (recent_pkts.size() > 32) recent_pkts.delete(0);
    end else if (pick < 58) begin
      if (recent_pkts.size() != 0) r.pkt = recent_pkts[$urandom_range(0, recent_pkts.size() - 1)];
    end else if (pick < 73) begin
      r.op = OpForward;
    end else if (pick < 96) begin
      r.op = OpCount;
      if (recent_pkts.size() != 0 && $urandom_range(0, 1) == 1)
        r.pkt.dst = recent_pkts[$urandom_range(0, recent_pkts.size() - 1)].dst;
      else if ($urandom_range(0, 3) != 0)
        r.pkt.dst = common_id($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        back  = $urandom_range(0, 40);
        ahead = $urandom_range(0, 40);
        r.lo  = (ts_cursor > back) ? ts_cursor - back : '0;
        r.hi  = (32'hFFFF_FFFF - ts_cursor < ahead) ? 32'hFFFF_FFFF : ts_cursor + ahead;
      end else if (pick < 75) begin
        r.lo = '0;
        r.hi = 32'hFFFF_FFFF;
      end else if (pick < 85) begin
        r.hi = ts_cursor;
        r.lo = ts_cursor + $urandom_range(1, 5);
      end
    end else begin
      r.op = OpNop;
    end
    return r;
  endfunction

  task automatic push_req(input pfd_op_e op, input logic [DefIdBits-1:0] s,
                          input logic [DefIdBits-1:0] d, input logic [DefTimeBits-1:0] t,
                          input logic [DefTimeBits-1:0] lo, input logic [DefTimeBits-1:0] hi);
    req_t r;
    r.op      = op;
    r.pkt.src = s;
    r.pkt.dst = d;
    r.pkt.ts  = t;
    r.lo      = lo;
    r.hi      = hi;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || replies_due.size() != 0 || drv_valid)
      @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(RegMemLimit * 4);
    pwdata  <= {21'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    limit_reg = val;
    n_limits++;
  endtask

  // request driver: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid     <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
      n_in_accepted <= 0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        replies_due.insert(replies_due.size(), serve_request(held_req));
        n_in_accepted <= n_in_accepted + 1;
      end
      if (drv_valid && !in_ch.ready) begin
      end else if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        drv_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        held_req = pending_reqs[0];
        pending_reqs.delete(0);
        drv_req   <= held_req;
        drv_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          if ($urandom_range(0, 3) == 0) gap_left <= 0;
          else if ($urandom_range(0, 7) == 0) gap_left <= $urandom_range(10, 40);
          else gap_left <= $urandom_range(1, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // one long receiver hold-off while requests keep coming
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed && n_in_accepted >= 120) begin
      hold_left  <= 600;
      hold_armed <= 1'b0;
    end
  end

  // reply monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready <= 1'b0;
      rx_tick  <= 0;
      rx_mode  <= 2'd0;
    end else begin
      if (out_ch.valid && rx_ready) begin
        seen.ok      = out_ch.ok;
        seen.pkt.src = out_ch.out_source;
        seen.pkt.dst = out_ch.out_destination;
        seen.pkt.ts  = out_ch.out_timestamp;
        seen.count   = out_ch.match_count;
        if (replies_due.size() == 0) begin
          flag_error($sformatf("transaction with nothing pending: ok=%0b count=%0d",
                               seen.ok, seen.count));
        end else begin
          want = replies_due[0];
          replies_due.delete(0);
          n_checked++;
          if (seen.ok !== want.ok)
            flag_error($sformatf("ok %0b, want %0b", seen.ok, want.ok));
          if (seen.pkt.src !== want.pkt.src)
            flag_error($sformatf("out_source %h, want %h", seen.pkt.src, want.pkt.src));
          if (seen.pkt.dst !== want.pkt.dst)
            flag_error($sformatf("out_destination %h, want %h", seen.pkt.dst, want.pkt.dst));
          if (seen.pkt.ts !== want.pkt.ts)
            flag_error($sformatf("out_timestamp %h, want %h", seen.pkt.ts, want.pkt.ts));
          if (seen.count !== want.count)
            flag_error($sformatf("match_count %0d, want %0d", seen.count, want.count));
        end
      end
      rx_tick <= rx_tick + 1;
      if (rx_tick % 97 == 0) rx_mode <= 2'($urandom_range(0, 3));
      case (rx_mode)
        2'd0:    rx_next = 1'b1;
        2'd1:    rx_next = 1'($urandom_range(0, 1));
        2'd2:    rx_next = ($urandom_range(0, 3) == 0);
        default: rx_next = (rx_tick % 5 != 0);
      endcase
      rx_ready <= rx_next && (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((drv_valid && in_ch.ready) || (out_ch.valid && rx_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("packet_fifo_dedup_window_count regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned i;
    int unsigned len;
    logic [LimitW-1:0] lim;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_req(OpForward, '0, '0, '0, '0, '0);
    push_req(OpCount, '0, '0, '0, '0, 32'hFFFF_FFFF);
    push_req(OpNop, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(OpAdd, '0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(OpAdd, '0, '0, '0, '0, '0);
    push_req(OpAdd, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, '0, '0);
    push_req(OpAdd, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, '0, '0);
    push_req(OpAdd, 16'h1234, 16'hFFFF, 32'd10, '0, '0);
    push_req(OpAdd, 16'h1234, 16'hFFFF, 32'd5, '0, '0);
    push_req(OpAdd, 16'h1235, 16'hFFFF, 32'd10, '0, '0);
    push_req(OpCount, 16'h5555, 16'hFFFF, 32'hAAAA_AAAA, 32'd5, 32'd10);
    push_req(OpCount, '0, 16'hFFFF, '0, '0, 32'hFFFF_FFFF);
    push_req(OpCount, '0, 16'hFFFF, '0, 32'd10, 32'd10);
    push_req(OpCount, '0, 16'hFFFF, '0, 32'd11, 32'd10);
    push_req(OpCount, '0, '0, '0, '0, '0);
    push_req(OpForward, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, '0, '0);
    push_req(OpAdd, '0, '0, '0, '0, '0);
    wait_idle();
    // shrink the limit below current occupancy
    write_limit(11'd2);
    push_req(OpAdd, 16'd7, 16'd7, 32'd20, '0, '0);
    push_req(OpAdd, 16'd8, 16'd8, 32'd21, '0, '0);
    push_req(OpCount, '0, 16'hFFFF, '0, '0, 32'hFFFF_FFFF);
    push_req(OpForward, '0, '0, '0, '0, '0);
    push_req(OpForward, '0, '0, '0, '0, '0);
    wait_idle();
    write_limit(11'd0);
    push_req(OpAdd, 16'd9, 16'd9, 32'd30, '0, '0);
    push_req(OpForward, '0, '0, '0, '0, '0);
    push_req(OpForward, '0, '0, '0, '0, '0);
    push_req(OpForward, '0, '0, '0, '0, '0);
    push_req(OpForward, '0, '0, '0, '0, '0);
    wait_idle();

    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin lim = 11'd2047; len = 70;  end
        1: begin lim = 11'd1;    len = 60;  end
        2: begin lim = 11'd5;    len = 80;  end
        3: begin lim = 11'd16;   len = 80;  end
        4: begin lim = 11'd1024; len = 120; end
        5: begin lim = 11'd3;    len = 60;  end
        6: begin lim = 11'd64;   len = 80;  end
        default: begin
          lim       = 11'($urandom_range(1, 40));
          len       = 30;
          ts_cursor = 32'hFFFF_FC00;
        end
      endcase
      write_limit(lim);
      for (i = 0; i < len; i++) pending_reqs.insert(pending_reqs.size(), random_req());
      wait_idle();
    end

    repeat (DefDepth + 8) @(posedge clk_i);
    if (replies_due.size() != 0)
      flag_error($sformatf("%0d transactions never returned", replies_due.size()));
    $display("Ran %0d requests: %0d adds, %0d refused as duplicates, %0d evictions,",
             n_in_accepted, n_added, n_dups, n_evicted);
    $display("  %0d forwards, %0d on empty store, %0d window counts (%0d nonzero), %0d limits",
             n_forwarded, n_fwd_empty, n_counts, n_hits, n_limits);
    if (n_errors == 0) begin
      $display("packet_fifo_dedup_window_count regression: pass");
    end else begin
      $display("packet_fifo_dedup_window_count regression: fail");
    end
    $finish;
  end

endmodule

@@ packet_fifo_dedup_window_count.f @@
design/pfd_pkg.sv
design/pfd_chan_if.sv
design/pfd_store.sv
design/packet_fifo_dedup_window_count.sv
design/pfd_checker.sv
tb/tb.sv
